// File: rtl/tefp_pkg.sv
// Package for the tensor element to binary32 converter.
// Holds payload structs, format codes and float field constants; no dependencies.
`default_nettype none
package tefp_pkg;
   typedef enum logic [1:0] {
      FMT_FP32   = 2'd0,
      FMT_FP16   = 2'd1,
      FMT_Q8_0   = 2'd2,
      FMT_UNSUPP = 2'd3
   } fmt_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [31:0]       raw_word;
      logic signed [7:0] quant_value;
   } req_type;

   typedef struct packed {
      logic [31:0] value_bits;
      logic        unsupported;
   } rsp_type;

   localparam logic [31:0] QNAN32  = 32'h7FC0_0000;
   localparam logic [31:0] QUIET32 = 32'h0040_0000;
   localparam logic [4:0]  H_EXP_MAX = 5'd31;
   localparam logic [7:0]  F_EXP_MAX = 8'd255;
endpackage
`default_nettype wire

// File: rtl/tensor_element_to_fp32.sv
// Top level: converts one tensor element per transaction to binary32 bits.
// The result strobe follows start through the input register and then the result register.
// Throughput: one transaction per cycle; busy is tied low and the receiver cannot stall.
// Reset: synchronous active-high reset clears both valid flags.
// Depends on tefp_pkg and tefp_convert.
`default_nettype none
module tensor_element_to_fp32 (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire tefp_pkg::req_type req_data,
   output logic               rsp_strobe,
   output tefp_pkg::rsp_type  rsp_data
);
   import tefp_pkg::*;

   req_type req_ff;
   logic    req_vld_ff, req_vld_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff;

   assign busy       = 1'b0;
   assign req_vld_in = start & ~busy;

   tefp_convert u_convert (.req(req_ff), .rsp(rsp_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= req_vld_ff;
      end
      if (req_vld_in) req_ff <= req_data;
      if (req_vld_ff) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/tefp_convert.sv
// Combinational conversion of one element to binary32 bits.
// Depends on tefp_pkg.
`default_nettype none
module tefp_convert (
   input  wire tefp_pkg::req_type req,
   output tefp_pkg::rsp_type rsp
);
   import tefp_pkg::*;

   logic [31:0] half_bits;
   logic [31:0] q_bits;

   // binary16 widening
   logic [15:0] h;
   logic [4:0]  h_ex;
   logic [9:0]  h_fr;
   logic [3:0]  h_p;
   logic [22:0] h_sub;
   always_comb begin
      h     = req.raw_word[15:0];
      h_ex  = h[14:10];
      h_fr  = h[9:0];
      h_p   = '0;
      for (int i = 0; i < 10; i++) begin
         if (h_fr[i]) h_p = 4'(i);
      end
      h_sub = 23'({13'd0, h_fr} << (5'd23 - {1'b0, h_p}));
      if (h_ex == '0) begin
         if (h_fr == '0) half_bits = {h[15], 31'd0};
         else half_bits = {h[15], 8'({4'd0, h_p} + 8'd103), h_sub};
      end else if (h_ex == H_EXP_MAX) begin
         if (h_fr == '0) half_bits = {h[15], 8'hFF, 23'd0};
         else half_bits = {h[15], 8'hFF, 1'b1, h_fr[8:0], 13'd0};
      end else begin
         half_bits = {h[15], 8'({3'd0, h_ex} + 8'd112), h_fr, 13'd0};
      end
   end

   // q8_0 scaling, round to nearest even
   logic [31:0] s;
   logic        qneg;
   logic [7:0]  qmag;
   logic        sgn;
   logic [7:0]  ex;
   logic [23:0] m;
   logic [31:0] prod;
   logic [4:0]  b;
   logic signed [10:0] e, be;
   logic [4:0]  sh;
   logic [31:0] rem, half, mant, mask;
   logic [31:0] subsh;
   always_comb begin
      s    = req.raw_word;
      qneg = req.quant_value[7];
      qmag = qneg ? 8'(9'd256 - {1'b0, req.quant_value}) : req.quant_value;
      sgn  = s[31] ^ qneg;
      ex   = s[30:23];
      if (ex == '0) begin
         m = {1'b0, s[22:0]};
         e = -11'sd149;
      end else begin
         m = {1'b1, s[22:0]};
         e = 11'(signed'({3'd0, ex})) - 11'sd150;
      end
      prod = {8'd0, m} * {24'd0, qmag};
      b = '0;
      for (int i = 0; i < 32; i++) begin
         if (prod[i]) b = 5'(i);
      end
      be    = 11'(signed'({6'd0, b})) + e + 11'sd127;
      subsh = prod << 5'(e + 11'sd149);
      sh    = '0;
      mask  = '0;
      rem   = '0;
      half  = '0;
      if (b > 5'd23) begin
         sh   = b - 5'd23;
         mask = (32'd1 << sh) - 32'd1;
         rem  = prod & mask;
         half = 32'd1 << (sh - 5'd1);
         mant = prod >> sh;
         if (rem > half || (rem == half && mant[0])) mant = mant + 32'd1;
         if (mant[24]) begin
            mant = mant >> 1;
            be   = be + 11'sd1;
         end
      end else begin
         mant = prod << (5'd23 - b);
      end
      if (ex == F_EXP_MAX) begin
         if (s[22:0] != '0) q_bits = s | QUIET32;
         else if (qmag == '0) q_bits = QNAN32;
         else q_bits = {sgn, 8'hFF, 23'd0};
      end else if (prod == '0) begin
         q_bits = {sgn, 31'd0};
      end else if (be < 11'sd1) begin
         q_bits = {sgn, subsh[30:0]};
      end else if (be >= 11'sd255) begin
         q_bits = {sgn, 8'hFF, 23'd0};
      end else begin
         q_bits = {sgn, be[7:0], mant[22:0]};
      end
   end

   always_comb begin
      rsp.unsupported = 1'b0;
      case (req.cmd)
         FMT_FP32: rsp.value_bits = req.raw_word;
         FMT_FP16: rsp.value_bits = half_bits;
         FMT_Q8_0: rsp.value_bits = q_bits;
         default: begin
            rsp.value_bits  = '0;
            rsp.unsupported = 1'b1;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/tefp_checker.sv
// Port-level checker for tensor_element_to_fp32, bound to the top level.
// Depends on tefp_pkg.
`default_nettype none
module tefp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire tefp_pkg::req_type req_data,
   input wire logic              rsp_strobe,
   input wire tefp_pkg::rsp_type rsp_data
);
   import tefp_pkg::*;

   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe) else $error("missing result");
   a_noextra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2)) else $error("spurious result");
   a_unsupp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == FMT_UNSUPP) |-> ##2
      (rsp_data.unsupported && rsp_data.value_bits == '0)) else $error("unsupported");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == FMT_FP32) |-> ##2
      (rsp_data.value_bits == $past(req_data.raw_word, 2) && !rsp_data.unsupported))
      else $error("passthrough");
endmodule

bind tensor_element_to_fp32 tefp_checker u_checker (.*);
`default_nettype wire
